### sv/gaussian_blur_5x5_stream_unit_macros.svh
// Assertion macros shared by the 5x5 Gaussian blur RTL.
// Stand-alone header: no dependencies. Each macro expects clk and rst_n in scope.
`ifndef GAUSSIAN_BLUR_5X5_STREAM_UNIT_MACROS_SVH
`define GAUSSIAN_BLUR_5X5_STREAM_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define GB5_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define GB5_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/gb5_pkg.sv
// Shared types, constants and the vertical kernel function of the 5x5 blur.
// No dependencies.
package gb5_pkg;

  localparam int PIX_W        = 8;
  localparam int KSIZE        = 5;
  localparam int HIST         = KSIZE - 1;
  localparam int ROW_LIMIT    = 1024;
  localparam int ROW_W        = 10;
  localparam int WIDTH_REG_W  = 10;
  localparam int HEIGHT_REG_W = 11;
  localparam int CFG_W        = 11;
  localparam int IDX_W        = 2;
  // One column weighted by 1 4 6 4 1 stays at or below 16 * 255.
  localparam int VSUM_W       = 12;
  // The full 5x5 sum stays below 256 * 256.
  localparam int HSUM_W       = 16;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [KSIZE-1:0][PIX_W-1:0] column_t;

  typedef enum logic [IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1
  } cfg_reg_t;

  // Binomial row of the kernel; the 2-D kernel is its outer product.
  localparam int unsigned BINOM [KSIZE] = '{1, 4, 6, 4, 1};

  // Weighted sum of one window column, oldest row first.
  function automatic logic [VSUM_W-1:0] vert_sum(input column_t col);
    logic [VSUM_W-1:0] acc;
    acc = '0;
    for (int k = 0; k < KSIZE; k++) begin
      acc = acc + VSUM_W'(col[k]) * VSUM_W'(BINOM[k]);
    end
    return acc;
  endfunction

endpackage

### sv/gb5_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module gb5_ram #(
  parameter int DATA_W = 32,
  parameter int DEPTH  = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  // Write and read ports; read data holds while re is low.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### sv/gb5_sum_cell.sv
// One cell of the window chain: holds the vertical sum of one window column.
// Depends on gb5_pkg.
module gb5_sum_cell #(
  parameter int unsigned WEIGHT = 1
) (
  input  logic                        clk,
  input  logic                        shift_en,
  input  logic [gb5_pkg::VSUM_W-1:0]  vsum_in,
  output logic [gb5_pkg::VSUM_W-1:0]  vsum_out,
  output logic [gb5_pkg::HSUM_W-1:0]  weighted
);
  import gb5_pkg::*;

  logic [VSUM_W-1:0] vsum_r;

  // Take the neighbor's column sum whenever the window slides.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      vsum_r <= vsum_in;
    end
  end

  assign vsum_out = vsum_r;

  // Horizontal weight of this cell's position; a small constant product.
  assign weighted = HSUM_W'(vsum_r) * HSUM_W'(WEIGHT);

endmodule

### sv/gaussian_blur_5x5_stream_unit.sv
// Top level of the streaming 5x5 Gaussian blur with line store and cell chain.
// Depends on gb5_pkg, gb5_ram, gb5_sum_cell and the macros header.
//
//   Channel  Dir  Handshake             Payload
//   in_      in   in_valid / in_ready   in_pixel_in
//   out_     out  out_valid / out_ready out_pixel_out, out_frame_end
//   cfg_     in   cfg_we                cfg_index, cfg_data
//
// One pixel per clock unless the output stalls; pixels pass s1, s2 and the output register.
// The rate is set by the line store, one read and one write per pixel.
// A stalled output holds the whole three-stage pipeline; an empty output register never stalls it.
// Reset is synchronous; there is no clearing pass, since rows and columns
// below four pass through, so old store contents never reach the output.
module gaussian_blur_5x5_stream_unit #(
  parameter int MAX_WIDTH = 512
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [gb5_pkg::PIX_W-1:0]        in_pixel_in,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [gb5_pkg::PIX_W-1:0]        out_pixel_out,
  output logic                             out_frame_end,
  input  logic                             cfg_we,
  input  logic [gb5_pkg::IDX_W-1:0]        cfg_index,
  input  logic [gb5_pkg::CFG_W-1:0]        cfg_data
);
  import gb5_pkg::*;
  `include "gaussian_blur_5x5_stream_unit_macros.svh"

  localparam int CW           = $clog2(MAX_WIDTH);
  localparam int WCW          = (CW + 1 > WIDTH_REG_W) ? CW + 1 : WIDTH_REG_W;
  localparam int RAM_W        = HIST * PIX_W;
  localparam int COL_LAST_RST = ((MAX_WIDTH < 512) ? MAX_WIDTH : 512) - 1;
  localparam int ROW_LAST_RST = 511;

  // Position counters and the last index of each, taken from configuration.
  logic [CW-1:0]    col_r, col_nxt, col_last_r, col_last_nxt, col_last_cfg;
  logic [ROW_W-1:0] row_r, row_nxt, row_last_r, row_last_nxt, row_last_cfg;
  logic [WCW-1:0]          wreq, wsel;
  logic [HEIGHT_REG_W-1:0] hreq, hsel;
  logic cfg_known;

  // Pipeline stages.
  logic          adv, in_xfer, shift_en;
  logic          s1_valid_r, s2_valid_r, out_valid_r;
  pix_t          s1_px_r, s2_px_r, out_pixel_r;
  logic [CW-1:0] s1_col_r;
  logic          s1_border_r, s1_last_r, s2_border_r, s2_last_r, out_last_r;
  logic          border_now, last_now;

  logic [RAM_W-1:0]  ram_rdata, ram_wdata;
  column_t           new_col;
  logic [VSUM_W-1:0] vsum_chain [KSIZE+1];
  logic [HSUM_W-1:0] weighted [KSIZE];
  logic [HSUM_W-1:0] hsum;

  // The pipeline advances when the output register is free or being drained.
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;
  assign in_xfer  = in_valid && adv;
  assign shift_en = adv && s1_valid_r;

  // Clamp a written width or height to the supported range.
  always_comb begin
    wreq = WCW'(cfg_data[WIDTH_REG_W-1:0]);
    if (wreq < WCW'(KSIZE)) begin
      wsel = WCW'(KSIZE);
    end else if (wreq > WCW'(MAX_WIDTH)) begin
      wsel = WCW'(MAX_WIDTH);
    end else begin
      wsel = wreq;
    end
    col_last_cfg = CW'(wsel - WCW'(1));

    hreq = cfg_data[HEIGHT_REG_W-1:0];
    if (hreq < HEIGHT_REG_W'(KSIZE)) begin
      hsel = HEIGHT_REG_W'(KSIZE);
    end else if (hreq > HEIGHT_REG_W'(ROW_LIMIT)) begin
      hsel = HEIGHT_REG_W'(ROW_LIMIT);
    end else begin
      hsel = hreq;
    end
    row_last_cfg = ROW_W'(hsel - HEIGHT_REG_W'(1));
  end

  assign cfg_known = cfg_we &&
                     (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);

  // Next frame size and raster position; a known register write restarts the frame.
  always_comb begin
    col_last_nxt = col_last_r;
    row_last_nxt = row_last_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    if (cfg_known) begin
      if (cfg_index == REG_IMAGE_WIDTH) begin
        col_last_nxt = col_last_cfg;
      end else begin
        row_last_nxt = row_last_cfg;
      end
      col_nxt = '0;
      row_nxt = '0;
    end else if (in_xfer) begin
      if (col_r == col_last_r) begin
        col_nxt = '0;
        row_nxt = (row_r == row_last_r) ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  assign border_now = (row_r < ROW_W'(HIST)) || (col_r < CW'(HIST));
  assign last_now   = (col_r == col_last_r) && (row_r == row_last_r);

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      col_last_r  <= CW'(COL_LAST_RST);
      row_last_r  <= ROW_W'(ROW_LAST_RST);
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      col_last_r <= col_last_nxt;
      row_last_r <= row_last_nxt;
      if (adv) begin
        s1_valid_r  <= in_xfer;
        s2_valid_r  <= s1_valid_r;
        out_valid_r <= s2_valid_r;
      end
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_px_r     <= in_pixel_in;
      s1_col_r    <= col_r;
      s1_border_r <= border_now;
      s1_last_r   <= last_now;
    end
    if (shift_en) begin
      s2_px_r     <= s1_px_r;
      s2_border_r <= s1_border_r;
      s2_last_r   <= s1_last_r;
    end
    if (adv && s2_valid_r) begin
      out_pixel_r <= s2_border_r ? s2_px_r : hsum[HSUM_W-1:HSUM_W-PIX_W];
      out_last_r  <= s2_last_r;
    end
  end

  // Line store: one word per column, byte k holds row r-4+k.
  gb5_ram #(
    .DATA_W (RAM_W),
    .DEPTH  (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (shift_en),
    .waddr (s1_col_r),
    .wdata (ram_wdata),
    .re    (in_xfer),
    .raddr (col_r),
    .rdata (ram_rdata)
  );

  // The column ages by one row: drop the oldest byte, add the new pixel on top.
  assign ram_wdata = {s1_px_r, ram_rdata[RAM_W-1:PIX_W]};

  // Full window column, oldest row first.
  always_comb begin
    for (int k = 0; k < HIST; k++) begin
      new_col[k] = ram_rdata[k*PIX_W +: PIX_W];
    end
    new_col[HIST] = s1_px_r;
  end

  assign vsum_chain[0] = vert_sum(new_col);

  // Chain of column cells: the window slides by one cell per pixel.
  for (genvar g = 0; g < KSIZE; g++) begin : g_cell
    gb5_sum_cell #(
      .WEIGHT (BINOM[g])
    ) u_cell (
      .clk      (clk),
      .shift_en (shift_en),
      .vsum_in  (vsum_chain[g]),
      .vsum_out (vsum_chain[g+1]),
      .weighted (weighted[g])
    );
  end

  // Horizontal sum of the weighted cells; the kernel weights total 256.
  always_comb begin
    hsum = '0;
    for (int k = 0; k < KSIZE; k++) begin
      hsum = hsum + weighted[k];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pixel_out = out_pixel_r;
  assign out_frame_end = out_last_r;

  // Checks on counters, restart and pipeline flow.
  `GB5_ASSERT_SAME(a_col_in_range, 1'b1, col_r <= col_last_r, "column index past frame width")
  `GB5_ASSERT_NEXT(a_cfg_restart, cfg_known, col_r == '0 && row_r == '0, "config did not restart frame")
  `GB5_ASSERT_NEXT(a_frame_wrap, in_xfer && last_now, col_r == '0 && row_r == '0, "frame did not wrap")
  `GB5_ASSERT_NEXT(a_result_reaches_out, adv && s2_valid_r, out_valid_r, "result lost before output")

endmodule
